@@ hdl/lra_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer with framebuffer addressing.
// No dependencies.
package lra_pkg;

  localparam int COORD_BITS_DEF = 11;
  localparam int OFFSET_W       = 12;
  localparam int BPP_W          = 3;
  localparam int STRIDE_W       = 16;
  localparam int ADDR_W         = 32;
  localparam int COLOR_W        = 32;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_OFFSET  = 2'd0,
    REG_Y_OFFSET  = 2'd1,
    REG_BPP       = 2'd2,
    REG_STRIDE    = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] x_offset;
    logic [OFFSET_W-1:0] y_offset;
    logic [BPP_W-1:0]    bytes_per_pixel;
    logic [STRIDE_W-1:0] line_stride;
  } cfg_t;

endpackage

@@ hdl/lra_front.sv @@
`timescale 1ns / 1ps
// Front end: classifies incoming items and does the line setup for loads
// (endpoint swap, deltas, octant, initial decision). Uses lra_pkg.
module lra_front #(
  parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
  input  logic                        cmd,
  input  logic [COORD_BITS-1:0]       x_start,
  input  logic [COORD_BITS-1:0]       y_start,
  input  logic [COORD_BITS-1:0]       x_end,
  input  logic [COORD_BITS-1:0]       y_end,
  output logic                        is_load,
  output logic [COORD_BITS-1:0]       first_x,
  output logic [COORD_BITS-1:0]       first_y,
  output logic [COORD_BITS-1:0]       last_x,
  output logic [COORD_BITS-1:0]       last_y,
  output logic [COORD_BITS-1:0]       delta_major,
  output logic [COORD_BITS-1:0]       delta_minor,
  output logic signed [COORD_BITS+2:0] decision,
  output logic                        y_down,
  output logic                        steep
);
  import lra_pkg::*;

  logic                  swap;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  always_comb begin
    is_load = (cmd == CMD_LOAD);
    swap    = (x_start > x_end);
    first_x = swap ? x_end : x_start;
    first_y = swap ? y_end : y_start;
    last_x  = swap ? x_start : x_end;
    last_y  = swap ? y_start : y_end;
    dx      = last_x - first_x;
    y_down  = (last_y < first_y);
    dy      = y_down ? (first_y - last_y) : (last_y - first_y);
    steep   = (dy > dx);
    delta_major = steep ? dy : dx;
    delta_minor = steep ? dx : dy;
    // 2*minor - major
    decision = $signed({2'b00, delta_minor, 1'b0}) - $signed({3'b000, delta_major});
  end

endmodule

@@ hdl/lra_fifo.sv @@
`timescale 1ns / 1ps
// Small register-based FIFO that decouples the setup front end from the stepper.
// No dependencies.
module lra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lra_back.sv @@
`timescale 1ns / 1ps
// Back end stepper: holds the active line and walks it one pixel per step
// transaction, handing each pixel to the address stage. Uses lra_pkg.
module lra_back #(
  parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic                          q_load,
  input  logic [COORD_BITS-1:0]         q_first_x,
  input  logic [COORD_BITS-1:0]         q_first_y,
  input  logic [COORD_BITS-1:0]         q_last_x,
  input  logic [COORD_BITS-1:0]         q_last_y,
  input  logic [COORD_BITS-1:0]         q_major,
  input  logic [COORD_BITS-1:0]         q_minor,
  input  logic signed [COORD_BITS+2:0]  q_decision,
  input  logic                          q_y_down,
  input  logic                          q_steep,
  input  logic [lra_pkg::COLOR_W-1:0]   q_color,
  output logic                          pix_valid,
  input  logic                          pix_ready,
  output logic [COORD_BITS-1:0]         pix_x,
  output logic [COORD_BITS-1:0]         pix_y,
  output logic [lra_pkg::COLOR_W-1:0]   pix_color,
  output logic                          pix_last
);
  import lra_pkg::*;

  localparam int DW = COORD_BITS + 3;

  logic                  active;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COORD_BITS-1:0] delta_major;
  logic [COORD_BITS-1:0] delta_minor;
  logic signed [DW-1:0]  decision;
  logic                  y_down;
  logic                  steep;
  logic [COLOR_W-1:0]    line_color;

  logic                  slot_free;
  logic                  emit;
  logic                  at_end;
  logic                  minor_step;
  logic [COORD_BITS-1:0] y_stepped;
  logic [COORD_BITS-1:0] x_stepped;
  logic signed [DW-1:0]  decision_next;

  always_comb begin
    slot_free  = !pix_valid || pix_ready;
    // loads and idle steps need no output slot
    q_pop      = q_valid && (q_load || !active || slot_free);
    emit       = q_pop && !q_load && active;
    at_end     = (cur_x == end_x) && (cur_y == end_y);
    minor_step = (decision >= 0);
    y_stepped  = y_down ? cur_y - 1'b1 : cur_y + 1'b1;
    x_stepped  = cur_x + 1'b1;
    decision_next = decision + $signed({2'b00, delta_minor, 1'b0});
    if (minor_step) begin
      decision_next = decision_next - $signed({2'b00, delta_major, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      cur_x       <= '0;
      cur_y       <= '0;
      end_x       <= '0;
      end_y       <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      decision    <= '0;
      y_down      <= 1'b0;
      steep       <= 1'b0;
      line_color  <= '0;
      pix_valid   <= 1'b0;
    end else begin
      if (emit) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
      if (q_pop && q_load) begin
        active      <= 1'b1;
        cur_x       <= q_first_x;
        cur_y       <= q_first_y;
        end_x       <= q_last_x;
        end_y       <= q_last_y;
        delta_major <= q_major;
        delta_minor <= q_minor;
        decision    <= q_decision;
        y_down      <= q_y_down;
        steep       <= q_steep;
        line_color  <= q_color;
      end else if (emit) begin
        if (at_end) begin
          active <= 1'b0;
        end else begin
          if (steep) begin
            cur_y <= y_stepped;
            if (minor_step) begin
              cur_x <= x_stepped;
            end
          end else begin
            cur_x <= x_stepped;
            if (minor_step) begin
              cur_y <= y_stepped;
            end
          end
          decision <= decision_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pix_x     <= cur_x;
      pix_y     <= cur_y;
      pix_color <= line_color;
      pix_last  <= at_end;
    end
  end

endmodule

@@ hdl/lra_addr.sv @@
`timescale 1ns / 1ps
// Address pipeline: offsets and scales the pixel coordinates into a framebuffer
// byte address over two stages and holds the output register. Uses lra_pkg.
module lra_addr #(
  parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lra_pkg::cfg_t                 cfg,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [COORD_BITS-1:0]         pix_x,
  input  logic [COORD_BITS-1:0]         pix_y,
  input  logic [lra_pkg::COLOR_W-1:0]   pix_color,
  input  logic                          pix_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [lra_pkg::ADDR_W-1:0]    byte_address,
  output logic [lra_pkg::COLOR_W-1:0]   color_out,
  output logic                          last_pixel
);
  import lra_pkg::*;

  localparam int SUM_W = ((COORD_BITS > OFFSET_W) ? COORD_BITS : OFFSET_W) + 1;
  localparam int PX_W  = SUM_W + BPP_W;
  localparam int PY_W  = SUM_W + STRIDE_W;

  logic [SUM_W-1:0]      x_sum;
  logic [SUM_W-1:0]      y_sum;
  logic [PX_W-1:0]       x_prod;
  logic [PY_W-1:0]       y_prod;

  logic                  s1_valid;
  logic                  s1_ready;
  logic                  out_ready;
  logic [PX_W-1:0]       s1_x_prod;
  logic [PY_W-1:0]       s1_y_prod;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;
  logic [COLOR_W-1:0]    s1_color;
  logic                  s1_last;

  always_comb begin
    out_ready = !out_valid || !out_stall;
    s1_ready  = !s1_valid || out_ready;
    pix_ready = s1_ready;
    x_sum  = SUM_W'(pix_x) + SUM_W'(cfg.x_offset);
    y_sum  = SUM_W'(pix_y) + SUM_W'(cfg.y_offset);
    x_prod = PX_W'(x_sum) * PX_W'(cfg.bytes_per_pixel);
    y_prod = PY_W'(y_sum) * PY_W'(cfg.line_stride);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pix_valid;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && pix_valid) begin
      s1_x_prod <= x_prod;
      s1_y_prod <= y_prod;
      s1_x      <= pix_x;
      s1_y      <= pix_y;
      s1_color  <= pix_color;
      s1_last   <= pix_last;
    end
    if (out_ready && s1_valid) begin
      byte_address <= ADDR_W'(s1_x_prod) + ADDR_W'(s1_y_prod);
      pixel_x      <= s1_x;
      pixel_y      <= s1_y;
      color_out    <= s1_color;
      last_pixel   <= s1_last;
    end
  end

endmodule

@@ hdl/line_rasterizer_fb_address.sv @@
`timescale 1ns / 1ps
// Top level of the Bresenham line rasterizer with framebuffer byte addressing.
// Instantiates lra_front, lra_fifo, lra_back and lra_addr; uses lra_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall): cmd 0 loads a line from two inclusive
//   endpoints and a color; cmd 1 asks for the next pixel. A step with no active
//   line is consumed and gives nothing. A load replaces any line in progress.
//   Output channel (out_valid / out_stall): one pixel per active step, with its
//   coordinates, byte address (x+x_offset)*bytes_per_pixel+(y+y_offset)*stride
//   modulo 2^32, color and a flag on the line's end point.
//   Config channel (cfg_valid / cfg_ready): always ready; write only while idle.
//   Throughput: one transaction per cycle in while in_stall is low, one pixel
//   per cycle out while out_stall is low; the stepper updates position and
//   decision term at the same clock edge. An accepted step passes the queue,
//   the stepper register, the multiply stage and the output register in turn.
//   A four-entry queue sits between setup and stepper; in_stall rises only
//   when it is full, which happens when the receiver holds out_stall.
//   A stalled pixel holds on the outputs until taken.
//   Reset (rst, synchronous) empties all stages, drops the active line and sets
//   offsets and stride to 0 and bytes_per_pixel to 4.
module line_rasterizer_fb_address #(
  parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lra_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [lra_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             cmd,
  input  logic [COORD_BITS-1:0]            x_start,
  input  logic [COORD_BITS-1:0]            y_start,
  input  logic [COORD_BITS-1:0]            x_end,
  input  logic [COORD_BITS-1:0]            y_end,
  input  logic [lra_pkg::COLOR_W-1:0]      color_in,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COORD_BITS-1:0]            pixel_x,
  output logic [COORD_BITS-1:0]            pixel_y,
  output logic [lra_pkg::ADDR_W-1:0]       byte_address,
  output logic [lra_pkg::COLOR_W-1:0]      color_out,
  output logic                             last_pixel
);
  import lra_pkg::*;

  localparam int DW      = COORD_BITS + 3;
  localparam int ENTRY_W = 1 + 6 * COORD_BITS + DW + 2 + COLOR_W;

  cfg_t cfg;

  // front outputs
  logic                  f_load;
  logic [COORD_BITS-1:0] f_first_x;
  logic [COORD_BITS-1:0] f_first_y;
  logic [COORD_BITS-1:0] f_last_x;
  logic [COORD_BITS-1:0] f_last_y;
  logic [COORD_BITS-1:0] f_major;
  logic [COORD_BITS-1:0] f_minor;
  logic signed [DW-1:0]  f_decision;
  logic                  f_y_down;
  logic                  f_steep;

  // queue
  logic                  q_full;
  logic                  q_push;
  logic                  q_pop;
  logic                  q_not_empty;
  logic [ENTRY_W-1:0]    q_in;
  logic [ENTRY_W-1:0]    q_out;

  logic                  q_load;
  logic [COORD_BITS-1:0] q_first_x;
  logic [COORD_BITS-1:0] q_first_y;
  logic [COORD_BITS-1:0] q_last_x;
  logic [COORD_BITS-1:0] q_last_y;
  logic [COORD_BITS-1:0] q_major;
  logic [COORD_BITS-1:0] q_minor;
  logic signed [DW-1:0]  q_decision;
  logic                  q_y_down;
  logic                  q_steep;
  logic [COLOR_W-1:0]    q_color;

  // stepper to address pipe
  logic                  pix_valid;
  logic                  pix_ready;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [COLOR_W-1:0]    pix_color;
  logic                  pix_last;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_offset        <= '0;
      cfg.y_offset        <= '0;
      cfg.bytes_per_pixel <= BPP_RESET;
      cfg.line_stride     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_X_OFFSET: cfg.x_offset        <= cfg_data[OFFSET_W-1:0];
        REG_Y_OFFSET: cfg.y_offset        <= cfg_data[OFFSET_W-1:0];
        REG_BPP:      cfg.bytes_per_pixel <= cfg_data[BPP_W-1:0];
        REG_STRIDE:   cfg.line_stride     <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  lra_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .cmd         (cmd),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .is_load     (f_load),
    .first_x     (f_first_x),
    .first_y     (f_first_y),
    .last_x      (f_last_x),
    .last_y      (f_last_y),
    .delta_major (f_major),
    .delta_minor (f_minor),
    .decision    (f_decision),
    .y_down      (f_y_down),
    .steep       (f_steep)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_in     = {f_load, f_first_x, f_first_y, f_last_x, f_last_y, f_major, f_minor,
                     f_decision, f_y_down, f_steep, color_in};

  lra_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  assign {q_load, q_first_x, q_first_y, q_last_x, q_last_y, q_major, q_minor,
          q_decision, q_y_down, q_steep, q_color} = q_out;

  lra_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_not_empty),
    .q_pop      (q_pop),
    .q_load     (q_load),
    .q_first_x  (q_first_x),
    .q_first_y  (q_first_y),
    .q_last_x   (q_last_x),
    .q_last_y   (q_last_y),
    .q_major    (q_major),
    .q_minor    (q_minor),
    .q_decision (q_decision),
    .q_y_down   (q_y_down),
    .q_steep    (q_steep),
    .q_color    (q_color),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_color  (pix_color),
    .pix_last   (pix_last)
  );

  lra_addr #(
    .COORD_BITS (COORD_BITS)
  ) u_addr (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix_x        (pix_x),
    .pix_y        (pix_y),
    .pix_color    (pix_color),
    .pix_last     (pix_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .byte_address (byte_address),
    .color_out    (color_out),
    .last_pixel   (last_pixel)
  );

endmodule

@@ test/line_rasterizer_fb_address_chk.sv @@
`timescale 1ns / 1ps
// Scoreboard for the line rasterizer: tracks register writes, predicts each pixel
// from accepted load/step transactions and compares the pixel channel. Uses lra_pkg.
module line_rasterizer_fb_address_chk #(
  parameter int CB = lra_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [lra_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lra_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            cmd,
  input  logic [CB-1:0]                   x_start,
  input  logic [CB-1:0]                   y_start,
  input  logic [CB-1:0]                   x_end,
  input  logic [CB-1:0]                   y_end,
  input  logic [lra_pkg::COLOR_W-1:0]     color_in,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [CB-1:0]                   pixel_x,
  input  logic [CB-1:0]                   pixel_y,
  input  logic [lra_pkg::ADDR_W-1:0]      byte_address,
  input  logic [lra_pkg::COLOR_W-1:0]     color_out,
  input  logic                            last_pixel,
  output int                              errors,
  output int                              pending,
  output int                              loads,
  output int                              steps,
  output int                              pixels
);

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [31:0]   addr;
    logic [31:0]   color;
    logic          last;
  } pixel_t;

  pixel_t pixel_q[$];

  // register copies
  logic [11:0] x_off;
  logic [11:0] y_off;
  logic [2:0]  bpp;
  logic [15:0] stride;

  // line walker state
  logic [CB-1:0] cur_x, cur_y, stop_x, stop_y;
  int            d_major, d_minor, decision;
  logic          down, steep, line_on;
  logic [31:0]   ink;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    if (errors < 40)
      $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want_v);
    errors++;
  endtask

  task automatic load_line(input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                           input logic [CB-1:0] xe, input logic [CB-1:0] ye,
                           input logic [31:0] col);
    logic [CB-1:0] t;
    int dx, dy;
    // walk with x rising
    if (xs > xe) begin
      t = xs; xs = xe; xe = t;
      t = ys; ys = ye; ye = t;
    end
    dx = int'(xe - xs);
    down = ye < ys;
    dy = down ? int'(ys - ye) : int'(ye - ys);
    steep = dy > dx;
    d_major = steep ? dy : dx;
    d_minor = steep ? dx : dy;
    decision = 2 * d_minor - d_major;
    cur_x = xs;
    cur_y = ys;
    stop_x = xe;
    stop_y = ye;
    ink = col;
    line_on = 1'b1;
  endtask

  task automatic plot_step();
    pixel_t p;
    logic [63:0] a;
    logic take_minor;
    if (!line_on) return;
    a = (64'(cur_x) + 64'(x_off)) * 64'(bpp) + (64'(cur_y) + 64'(y_off)) * 64'(stride);
    p.x = cur_x;
    p.y = cur_y;
    p.addr = a[31:0];
    p.color = ink;
    p.last = (cur_x == stop_x) && (cur_y == stop_y);
    pixel_q.push_back(p);
    if (p.last) begin
      line_on = 1'b0;
    end else begin
      take_minor = decision >= 0;  // zero takes the minor step
      if (steep) begin
        cur_y = down ? cur_y - 1'b1 : cur_y + 1'b1;
        if (take_minor) cur_x = cur_x + 1'b1;
      end else begin
        cur_x = cur_x + 1'b1;
        if (take_minor) cur_y = down ? cur_y - 1'b1 : cur_y + 1'b1;
      end
      decision += 2 * d_minor;
      if (take_minor) decision -= 2 * d_major;
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      x_off = '0;
      y_off = '0;
      bpp = lra_pkg::BPP_RESET;
      stride = '0;
      cur_x = '0; cur_y = '0; stop_x = '0; stop_y = '0;
      d_major = 0; d_minor = 0; decision = 0;
      down = 1'b0; steep = 1'b0; line_on = 1'b0;
      ink = '0;
      pixel_q.delete();
      errors = 0;
      loads <= 0;
      steps <= 0;
      pixels <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (lra_pkg::cfg_reg_t'(cfg_index))
          lra_pkg::REG_X_OFFSET: x_off = cfg_data[11:0];
          lra_pkg::REG_Y_OFFSET: y_off = cfg_data[11:0];
          lra_pkg::REG_BPP:      bpp = cfg_data[2:0];
          lra_pkg::REG_STRIDE:   stride = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("unexpected pixel, address", byte_address, '0);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x !== want.x) report_mismatch("pixel_x", 32'(pixel_x), 32'(want.x));
          if (pixel_y !== want.y) report_mismatch("pixel_y", 32'(pixel_y), 32'(want.y));
          if (byte_address !== want.addr) report_mismatch("byte_address", byte_address, want.addr);
          if (color_out !== want.color) report_mismatch("color_out", color_out, want.color);
          if (last_pixel !== want.last)
            report_mismatch("last_pixel", 32'(last_pixel), 32'(want.last));
        end
        pixels <= pixels + 1;
      end
      if (in_valid && !in_stall) begin
        if (lra_pkg::cmd_t'(cmd) == lra_pkg::CMD_LOAD) begin
          load_line(x_start, y_start, x_end, y_end, color_in);
          loads <= loads + 1;
        end else begin
          plot_step();
          steps <= steps + 1;
        end
      end
    end
    pending <= pixel_q.size();
  end

endmodule

@@ test/line_rasterizer_fb_address_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for line_rasterizer_fb_address: drives config, load/step and
// pixel-side stall; checking lives in line_rasterizer_fb_address_chk. Uses lra_pkg.
module line_rasterizer_fb_address_tb;

  import lra_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int MAXC = (1 << CB) - 1;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 90;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   cmd = CMD_STEP;
  logic [CB-1:0]          x_start = '0;
  logic [CB-1:0]          y_start = '0;
  logic [CB-1:0]          x_end = '0;
  logic [CB-1:0]          y_end = '0;
  logic [COLOR_W-1:0]     color_in = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CB-1:0]          pixel_x;
  logic [CB-1:0]          pixel_y;
  logic [ADDR_W-1:0]      byte_address;
  logic [COLOR_W-1:0]     color_out;
  logic                   last_pixel;

  int errors, pending, loads, steps, pixels;
  int calm_in = 0;
  int calm_out = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int unsigned cycle_count = 0;

  line_rasterizer_fb_address #(.COORD_BITS(CB)) u_dut (.*);

  line_rasterizer_fb_address_chk #(.CB(CB)) u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("line_rasterizer_fb_address_tb failed");
      $finish;
    end
  end

  // pixel side: random stall per transaction, one long hold on request
  initial begin
    int n;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (hold_go && !hold_done) begin
        n = HOLD_CYCLES;
        hold_done = 1'b1;
      end else if (calm_out > 0) begin
        n = 0;
        calm_out--;
      end else begin
        n = $urandom_range(0, 4);
        if ($urandom_range(0, 19) == 0) calm_out = 30;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        for (int k = 0; k < n; k++) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input cmd_t c, input logic [CB-1:0] xs, input logic [CB-1:0] ys,
                           input logic [CB-1:0] xe, input logic [CB-1:0] ye,
                           input logic [31:0] col);
    int gap;
    if (calm_in > 0) begin
      gap = 0;
      calm_in--;
    end else begin
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 19) == 0) calm_in = 25;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    x_start <= xs;
    y_start <= ys;
    x_end <= xe;
    y_end <= ye;
    color_in <= col;
    do @(posedge clk); while (in_stall);
  endtask

  // step with junk in the unused fields
  task automatic send_step();
    send_item(CMD_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom), $urandom);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // junk above the offset and bpp register widths must be ignored
  task automatic write_settings(input logic [11:0] xo, input logic [11:0] yo,
                                input logic [2:0] bpp, input logic [15:0] stride);
    cfg_valid <= 1'b1;
    put_reg(REG_X_OFFSET, {4'($urandom), xo});
    put_reg(REG_Y_OFFSET, {4'($urandom), yo});
    put_reg(REG_BPP, {13'($urandom), bpp});
    put_reg(REG_STRIDE, stride);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, all pixels back, then room for loads or idle steps still in the pipe
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CB-1:0] near(input logic [CB-1:0] c, input int d);
    if ($urandom_range(0, 1) && int'(c) >= d) return CB'(int'(c) - d);
    if (int'(c) + d <= MAXC) return CB'(int'(c) + d);
    if (int'(c) >= d) return CB'(int'(c) - d);
    return CB'($urandom);
  endfunction

  task automatic directed();
    send_step();                                            // no line yet
    send_item(CMD_LOAD, '0, '0, '0, '0, 32'hFFFF_FFFF);     // single point
    send_step();
    send_step();                                            // line already done
    send_item(CMD_LOAD, 11'd2047, 11'd2047, 11'd2045, 11'd2046, 32'h0); // swapped, tie
    repeat (3) send_step();
    send_item(CMD_LOAD, '0, 11'd2047, 11'd2047, '0, 32'hA5A5_A5A5); // full diagonal
    repeat (2) send_step();
    send_item(CMD_LOAD, 11'd5, '0, 11'd6, 11'd2047, 32'h5A5A_5A5A); // steep, replaces
    repeat (2) send_step();
    send_item(CMD_LOAD, 11'd100, 11'd10, 11'd100, 11'd7, 32'h1234_5678); // vertical down
    repeat (5) send_step();
  endtask

  // long line, then the pixel side holds off so the input backs up
  task automatic pressure();
    send_item(CMD_LOAD, 11'd10, 11'd40, 11'd400, 11'd10, $urandom);
    calm_in = 60;
    hold_go = 1'b1;
    repeat (150) send_step();
  endtask

  task automatic run_phase(input int quota);
    int count, pick, span, dx, dy, len, n_steps;
    logic [CB-1:0] xs, ys, xe, ye;
    count = 0;
    while (count < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_item(cmd_t'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
                  CB'($urandom), CB'($urandom), $urandom);
        count++;
      end else begin
        span = (pick < 80) ? 12 : ((pick < 94) ? 60 : MAXC);
        xs = CB'($urandom);
        ys = CB'($urandom);
        xe = near(xs, $urandom_range(0, span));
        ye = near(ys, $urandom_range(0, span));
        dx = (xe > xs) ? int'(xe - xs) : int'(xs - xe);
        dy = (ye > ys) ? int'(ye - ys) : int'(ys - ye);
        len = ((dx > dy) ? dx : dy) + 1;
        n_steps = len + $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) n_steps = $urandom_range(0, len);
        if (n_steps > 60) n_steps = 60;
        send_item(CMD_LOAD, xs, ys, xe, ye, $urandom);
        repeat (n_steps) send_step();
        count += 1 + n_steps;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_settings(12'hFFF, 12'hFFF, 3'd7, 16'hFFFF);
    directed();
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      case (ph)
        0: write_settings(12'h000, 12'h000, 3'd1, 16'h0000);
        1: write_settings(12'($urandom), 12'($urandom), 3'd4, 16'd2560);
        2: write_settings(12'hFFF, 12'hFFF, 3'd0, 16'hFFFF);
        3: write_settings(12'($urandom), 12'($urandom), 3'($urandom), 16'($urandom));
        default: write_settings(12'd123, 12'd77, 3'd3, 16'd8192);
      endcase
      if (ph == 1) pressure();
      run_phase(130);
    end
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
    $display("Covered %0d line loads and %0d step transactions over six register settings,",
             loads, steps);
    $display("%0d pixels compared, including a long output hold that stalled the input.",
             pixels);
    if (errors == 0) begin
      $display("line_rasterizer_fb_address_tb passed");
    end else begin
      $display("line_rasterizer_fb_address_tb failed");
    end
    $finish;
  end

endmodule
